/* design/pkc_pkg.sv */
`default_nettype none

package pkc_pkg;

    // Default packet size limit; bytes beyond it are dropped.
    localparam int MAX_BYTES_DEF = 256;

    // Reflected CRC-32 polynomial and initial value.
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    // Reset value of the expected start marker.
    localparam logic [31:0] MARKER_RESET = 32'hAA55_AA55;

    // Bytes in the marker word and in the CRC word.
    localparam int WORD_BYTES = 4;

    // Width of the reported packet length.
    localparam int LEN_W = 9;

    // Frame status codes.
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_SHORT   = 2'd1,
        ST_CRC_ERR = 2'd2
    } t_status;

    // One input item: a packet byte and its end-of-packet flag.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    // One result item, produced at the end of each packet.
    typedef struct packed {
        t_status            status;
        logic               marker_ok;
        logic [31:0]        received_crc;
        logic [31:0]        computed_crc;
        logic [LEN_W-1:0]   packet_length;
    } t_out_item;

    // Input register contents handed to the frame checker.
    typedef struct packed {
        logic     valid;
        t_in_item item;
    } t_stage;

    // One byte through the reflected CRC-32, bit by bit.
    function automatic logic [31:0] crc_feed(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

/* design/pkc_in_stage.sv */
`default_nettype none

module pkc_in_stage
    import pkc_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_in_item i_in_item,
    input  wire logic     i_advance,
    output t_stage        o_stage
);

    logic     r_valid;
    t_in_item r_item;

    // The register takes a new item when it is empty or drains this cycle.
    assign o_in_ready = !r_valid || i_advance;

    // Valid flag of the input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
    end

    // Payload of the input register.
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_item <= i_in_item;
        end
    end

    assign o_stage.valid = r_valid;
    assign o_stage.item  = r_item;

endmodule

`default_nettype wire

/* design/pkc_frame_check.sv */
`default_nettype none

module pkc_frame_check
    import pkc_pkg::*;
#(
    parameter int MAX_BYTES = MAX_BYTES_DEF
)
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_stage      i_stage,
    output logic             o_advance,
    input  wire logic        i_cfg_we,
    input  wire logic [31:0] i_cfg_wdata,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output t_out_item        o_out_item
);

    // The count is at least as wide as the reported length field.
    localparam int CW = ($clog2(MAX_BYTES + 1) > LEN_W) ? $clog2(MAX_BYTES + 1) : LEN_W;

    logic [31:0] r_marker;
    logic [31:0] r_crc;
    logic [31:0] r_tail;
    logic [31:0] r_head;
    logic [CW-1:0] r_count;
    logic        r_out_valid;
    t_out_item   r_out;

    logic [31:0] n_crc;
    logic [31:0] n_tail;
    logic [31:0] n_head;
    logic [CW-1:0] n_count;
    logic        kept;
    logic        in_last;
    logic        emit;
    t_out_item   n_out;

    // A byte may pass unless it ends a packet while a result still waits.
    assign in_last   = i_stage.item.last_byte;
    assign o_advance = i_stage.valid && (!in_last || !r_out_valid || i_out_ready);
    assign emit      = o_advance && in_last;

    // Packet state update for the byte in the input register.
    always_comb begin
        kept    = r_count < CW'(MAX_BYTES);
        n_crc   = r_crc;
        n_tail  = r_tail;
        n_head  = r_head;
        n_count = r_count;
        if (kept) begin
            if (r_count < CW'(WORD_BYTES)) begin
                for (int i = 0; i < WORD_BYTES; i++) begin
                    if (r_count == CW'(i)) begin
                        n_head[8*i +: 8] = i_stage.item.data_byte;
                    end
                end
            end else begin
                n_crc = crc_feed(r_crc, r_tail[7:0]);
            end
            n_tail  = {i_stage.item.data_byte, r_tail[31:8]};
            n_count = r_count + CW'(1);
        end
    end

    // Result for a packet that ends with this byte.
    always_comb begin
        n_out.packet_length = n_count[LEN_W-1:0];
        if (n_count < CW'(WORD_BYTES)) begin
            n_out.status       = ST_SHORT;
            n_out.marker_ok    = 1'b0;
            n_out.received_crc = '0;
            n_out.computed_crc = '0;
        end else begin
            n_out.status       = (n_tail == ~n_crc) ? ST_OK : ST_CRC_ERR;
            n_out.marker_ok    = (n_head == r_marker);
            n_out.received_crc = n_tail;
            n_out.computed_crc = ~n_crc;
        end
    end

    // Expected marker register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_marker <= MARKER_RESET;
        end else if (i_cfg_we) begin
            r_marker <= i_cfg_wdata;
        end
    end

    // Packet state; it returns to its start values after each packet.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc   <= CRC_INIT;
            r_tail  <= '0;
            r_head  <= '0;
            r_count <= '0;
        end else if (emit) begin
            r_crc   <= CRC_INIT;
            r_tail  <= '0;
            r_head  <= '0;
            r_count <= '0;
        end else if (o_advance) begin
            r_crc   <= n_crc;
            r_tail  <= n_tail;
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    // Result register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // The kept byte count never passes the limit.
    a_count_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_BYTES))
        else $error("byte count above limit");

    // A packet end must not overwrite a result that is still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready && i_stage.valid && in_last) |-> !o_advance)
        else $error("pending result overwritten");

    // After a packet ends, the state starts over.
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |=> (r_count == '0 && r_crc == CRC_INIT && r_head == '0))
        else $error("packet state not cleared");

    // A short packet reports fewer than four bytes and zero fields.
    a_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status == ST_SHORT) |->
        (r_out.packet_length < LEN_W'(WORD_BYTES) && r_out.computed_crc == '0))
        else $error("inconsistent short packet result");

endmodule

`default_nettype wire

/* design/packet_crc32_checker_unit.sv */
// An accepted item first enters the input register; when a packet's last byte leaves it,
// the packet's result is written into the result register, where it waits to be taken.
// Throughput: one byte per cycle; the byte-wide CRC update sits between the input
// register and the packet state. Only a packet's last byte stalls, while a result waits.
// Reset is synchronous and active low: packet state clears and the marker is 0xAA55AA55.
`default_nettype none

module packet_crc32_checker_unit
    import pkc_pkg::*;
#(
    parameter int MAX_BYTES = MAX_BYTES_DEF
)
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire t_in_item    i_in_item,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output t_out_item        o_out_item,
    input  wire logic        i_cfg_we,
    input  wire logic [31:0] i_cfg_wdata
);

    t_stage stage;
    logic   advance;

    // Input register.
    pkc_in_stage u_in_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .i_advance  (advance),
        .o_stage    (stage)
    );

    // Packet state, CRC update and result register.
    pkc_frame_check #(
        .MAX_BYTES (MAX_BYTES)
    ) u_frame_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_stage     (stage),
        .o_advance   (advance),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

`default_nettype wire

/* verif/packet_crc32_checker_unit_tb.sv */
`default_nettype none

module packet_crc32_checker_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pkc_pkg::*;

    // Cycles with no item moving on either channel before the run is abandoned.
    localparam int STALL_LIMIT = 1000;

    // Tracks the frame in progress, predicts each frame verdict and checks the results.
    class crc_frame_board;
        logic [31:0] marker;
        logic [31:0] crc_acc;
        logic [31:0] tail_bytes;
        logic [31:0] head_bytes;
        int          kept;
        t_out_item   verdicts[$];
        int          failures;

        function new();
            marker   = MARKER_RESET;
            failures = 0;
            clear_frame();
        endfunction

        // One byte through the reflected CRC-32, data bits folded into the feedback.
        static function logic [31:0] crc32_byte(logic [31:0] crc, logic [7:0] b);
            logic [31:0] c;
            c = crc;
            for (int k = 0; k < 8; k++) begin
                c = (c >> 1) ^ (CRC_POLY & {32{c[0] ^ b[k]}});
            end
            return c;
        endfunction

        function void clear_frame();
            crc_acc    = CRC_INIT;
            tail_bytes = '0;
            head_bytes = '0;
            kept       = 0;
        endfunction

        function void note_failure(string msg);
            failures++;
            if (failures <= 10) begin
                $display("%t: %s", $realtime, msg);
            end
        endfunction

        // Bytes lag four places behind so the CRC word never enters the CRC.
        function void note_byte(t_in_item item);
            t_out_item   want;
            logic [31:0] computed;
            if (kept < MAX_BYTES_DEF) begin
                if (kept < WORD_BYTES) begin
                    head_bytes[8*kept +: 8] = item.data_byte;
                end else begin
                    crc_acc = crc32_byte(crc_acc, tail_bytes[7:0]);
                end
                tail_bytes = {item.data_byte, tail_bytes[31:8]};
                kept++;
            end
            if (!item.last_byte) begin
                return;
            end
            if (kept < WORD_BYTES) begin
                want.status       = ST_SHORT;
                want.marker_ok    = 1'b0;
                want.received_crc = '0;
                want.computed_crc = '0;
            end else begin
                computed          = ~crc_acc;
                want.status       = (tail_bytes == computed) ? ST_OK : ST_CRC_ERR;
                want.marker_ok    = (head_bytes == marker);
                want.received_crc = tail_bytes;
                want.computed_crc = computed;
            end
            want.packet_length = kept[LEN_W-1:0];
            verdicts.push_back(want);
            clear_frame();
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (verdicts.size() == 0) begin
                note_failure($sformatf(
                    "result with none pending: st=%0d mk=%0b rx=%h crc=%h len=%0d",
                    got.status, got.marker_ok, got.received_crc, got.computed_crc,
                    got.packet_length));
                return;
            end
            want = verdicts.pop_front();
            if (got.status !== want.status || got.marker_ok !== want.marker_ok ||
                got.received_crc !== want.received_crc ||
                got.computed_crc !== want.computed_crc ||
                got.packet_length !== want.packet_length) begin
                note_failure($sformatf({
                    "mismatch: want st=%0d mk=%0b rx=%h crc=%h len=%0d, ",
                    "got st=%0d mk=%0b rx=%h crc=%h len=%0d"},
                    want.status, want.marker_ok, want.received_crc, want.computed_crc,
                    want.packet_length, got.status, got.marker_ok, got.received_crc,
                    got.computed_crc, got.packet_length));
            end
        endfunction

        // Any verdict still waiting at the end is a missing result.
        function void close_out();
            while (verdicts.size() != 0) begin
                void'(verdicts.pop_front());
                note_failure("frame verdict never delivered");
            end
        endfunction
    endclass

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_ready;
    t_in_item    i_in_item   = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out_item   o_out_item;
    logic        i_cfg_we    = 1'b0;
    logic [31:0] i_cfg_wdata = '0;

    crc_frame_board board;
    logic [31:0]    marker_now   = MARKER_RESET;
    int             burst_left   = 0;
    int             idle_cycles  = 0;
    logic [15:0]    ready_pattern = 16'hFFFF;
    int             pattern_turns = 0;

    packet_crc32_checker_unit #(
        .MAX_BYTES (MAX_BYTES_DEF)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // 8 ns clock.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Result side stalls on a rotating pattern, replaced whenever its turn counter runs out.
    always @(posedge i_clk) begin
        logic [15:0] pat;
        if (pattern_turns == 0) begin
            pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
        end else begin
            pat = {ready_pattern[0], ready_pattern[15:1]};
        end
        pattern_turns <= (pattern_turns == 0) ? 63 : pattern_turns - 1;
        ready_pattern <= pat;
        i_out_ready   <= pat[0];
    end

    // Watch both handshakes; a long stretch with nothing moving ends the run.
    always @(posedge i_clk) begin
        bit moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                board.note_byte(i_in_item);
                moved = 1'b1;
            end
            if (o_out_valid && i_out_ready) begin
                board.check_result(o_out_item);
                moved = 1'b1;
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // Offer one byte, in bursts of random length separated by short gaps.
    task automatic send_byte(input logic [7:0] b, input logic last);
        t_in_item item;
        if (burst_left == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? 300 : $urandom_range(1, 24);
        end
        item.data_byte = b;
        item.last_byte = last;
        i_in_valid <= 1'b1;
        i_in_item  <= item;
        do @(posedge i_clk); while (!o_in_ready);
        burst_left--;
    endtask

    task automatic send_frame(ref logic [7:0] frame[$]);
        for (int i = 0; i < frame.size(); i++) begin
            send_byte(frame[i], i == frame.size() - 1);
        end
    endtask

    // Stop offering bytes and wait until every frame verdict has come back.
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (board.verdicts.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_marker(input logic [31:0] value);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we     <= 1'b0;
        board.marker = value;
        marker_now   = value;
    endtask

    function automatic void push_word(ref logic [7:0] q[$], input logic [31:0] w);
        for (int k = 0; k < 4; k++) begin
            q.push_back(w[8*k +: 8]);
        end
    endfunction

    // Append the little-endian CRC word over everything already in the frame.
    function automatic void append_crc(ref logic [7:0] q[$]);
        logic [31:0] c;
        c = CRC_INIT;
        foreach (q[i]) begin
            c = crc_frame_board::crc32_byte(c, q[i]);
        end
        push_word(q, ~c);
    endfunction

    function automatic void push_random(ref logic [7:0] q[$], input int count);
        for (int i = 0; i < count; i++) begin
            q.push_back(8'($urandom));
        end
    endfunction

    // Mostly well-formed frames with random content, the rest short frames, four-byte frames and noise.
    task automatic random_frames(input int budget);
        logic [7:0] frame[$];
        int         sent;
        int         r;
        int         idx;
        sent = 0;
        while (sent < budget) begin
            frame.delete();
            r = $urandom_range(0, 99);
            if (r < 60) begin
                push_word(frame, (r < 50) ? marker_now : 32'($urandom));
                push_random(frame, ($urandom_range(0, 9) == 0) ? $urandom_range(25, 80)
                                                                 : $urandom_range(0, 24));
                append_crc(frame);
                if ($urandom_range(0, 9) == 0) begin
                    idx = $urandom_range(0, frame.size() - 1);
                    frame[idx][$urandom_range(0, 7)] ^= 1'b1;
                end
            end else if (r < 72) begin
                push_random(frame, $urandom_range(1, 3));
            end else if (r < 78) begin
                if (r < 75) begin
                    push_word(frame, marker_now);
                end else begin
                    push_random(frame, 4);
                end
            end else begin
                push_random(frame, $urandom_range(5, 30));
            end
            send_frame(frame);
            sent += frame.size();
        end
    endtask

    initial begin
        logic [7:0]  frame[$];
        logic [31:0] phase_marker;
        board = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: short frames of one and three bytes.
        frame = '{8'hFF};
        send_frame(frame);
        frame = '{8'h00, 8'h00, 8'h00};
        send_frame(frame);
        // Exactly four bytes: empty CRC, zero word matches.
        frame = '{8'h00, 8'h00, 8'h00, 8'h00};
        send_frame(frame);
        // Marker alone: marker good, CRC bad.
        frame.delete();
        push_word(frame, MARKER_RESET);
        send_frame(frame);
        // Good frame with extreme payload bytes.
        frame.delete();
        push_word(frame, MARKER_RESET);
        frame.push_back(8'h00);
        frame.push_back(8'hFF);
        frame.push_back(8'h80);
        append_crc(frame);
        send_frame(frame);

        for (int p = 0; p < 5; p++) begin
            case (p)
                1: phase_marker = 32'h0000_0000;
                2: phase_marker = 32'hFFFF_FFFF;
                3: phase_marker = 32'($urandom);
                4: phase_marker = MARKER_RESET;
                default: phase_marker = marker_now;
            endcase
            if (p > 0) begin
                write_marker(phase_marker);
            end
            // Full-size frame, then one running past the limit with junk after it.
            if (p == 2) begin
                frame.delete();
                push_word(frame, marker_now);
                push_random(frame, MAX_BYTES_DEF - 8);
                append_crc(frame);
                send_frame(frame);
                push_random(frame, $urandom_range(1, 12));
                send_frame(frame);
            end
            random_frames(210);
        end

        settle();
        board.close_out();
        if (board.failures == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire
